@@ rtl/cidl_pkg.sv @@
// ----------------------------------------------------------------------------
// cidl_pkg
// Shared types and constants for the compacting identifier list.
// ----------------------------------------------------------------------------
package cidl_pkg;

    // fixed field widths of the transaction ports
    localparam int FUNC_W   = 2;
    localparam int SIG_W    = 16;
    localparam int COUNT_W  = 7;

    typedef logic [FUNC_W-1:0]  func_t;
    typedef logic [SIG_W-1:0]   sig_t;
    typedef logic [COUNT_W-1:0] count_t;

    // operation codes
    localparam func_t FUNC_APPEND = 2'd0;
    localparam func_t FUNC_REMOVE = 2'd1;
    localparam func_t FUNC_CLEAR  = 2'd2;

endpackage

@@ rtl/cidl_ram.sv @@
// ----------------------------------------------------------------------------
// cidl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cidl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/compacting_id_list_core.sv @@
// Sequence: append, clear and unused codes go from idle straight to the finish
//   state, where the registered result is loaded; remove scans the list first.
//   A stalled result holds the sequencer in its finish state.
// Throughput: one operation at a time; remove is bounded by the scan through the
//   list memory, one entry per cycle over one shared compare unit.
// Reset (rst_n, async, active low) empties the list; list storage is not cleared.
// ----------------------------------------------------------------------------
// compacting_id_list_core
// Ordered list of identifiers with append, remove-all-equal with in-place
// compaction, and clear. One result transaction per operation.
// ----------------------------------------------------------------------------
module compacting_id_list_core
    import cidl_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int ID_BITS  = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    // operation channel
    input  logic   req_valid,
    output logic   req_stall,
    input  func_t  func,
    input  sig_t   signal_id,
    // result channel
    output logic   rsp_valid,
    input  logic   rsp_stall,
    output count_t entry_count,
    output count_t removed_count,
    output logic   overflow
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   wr_reg, wr_next;
    logic               pend_reg, pend_next;
    logic [CNT_W-1:0]   removed_reg, removed_next;
    func_t              op_reg, op_next;
    logic [ID_BITS-1:0] key_reg, key_next;

    logic               rsp_valid_reg, rsp_valid_next;
    count_t             entry_count_reg, entry_count_next;
    count_t             removed_count_reg, removed_count_next;
    logic               overflow_reg, overflow_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ID_BITS-1:0] ram_wdata;
    logic               ram_re;
    logic [ID_BITS-1:0] ram_rdata;

    logic               req_take;
    logic               slot_free;
    logic               keep_entry;

    cidl_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    // shared compare unit: keep entries that differ from the key
    assign keep_entry = (ram_rdata != key_reg);

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        fill_next          = fill_reg;
        rd_next            = rd_reg;
        wr_next            = wr_reg;
        pend_next          = pend_reg;
        removed_next       = removed_reg;
        op_next            = op_reg;
        key_next           = key_reg;
        rsp_valid_next     = rsp_valid_reg && rsp_stall;
        entry_count_next   = entry_count_reg;
        removed_count_next = removed_count_reg;
        overflow_next      = overflow_reg;
        ram_we             = 1'b0;
        ram_waddr          = wr_reg[AW-1:0];
        ram_wdata          = ram_rdata;
        ram_re             = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    op_next      = func;
                    key_next     = ID_BITS'(signal_id);
                    rd_next      = '0;
                    wr_next      = '0;
                    pend_next    = 1'b0;
                    removed_next = '0;
                    state_next   = (func == FUNC_REMOVE) ? ST_SCAN : ST_FINISH;
                end
            end

            ST_SCAN:
            begin
                // issue next read
                if (rd_reg < fill_reg)
                begin
                    ram_re    = 1'b1;
                    rd_next   = rd_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // compact the entry read last cycle
                if (pend_reg && keep_entry)
                begin
                    ram_we  = 1'b1;
                    wr_next = wr_reg + 1'b1;
                end
                // all entries read and written back
                if ((rd_reg == fill_reg) && !pend_reg)
                begin
                    fill_next    = wr_reg;
                    removed_next = fill_reg - wr_reg;
                    state_next   = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (slot_free)
                begin
                    overflow_next      = 1'b0;
                    removed_count_next = '0;
                    case (op_reg)
                        FUNC_APPEND:
                        begin
                            if (fill_reg < CNT_W'(CAPACITY))
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = fill_reg[AW-1:0];
                                ram_wdata = key_reg;
                                fill_next = fill_reg + 1'b1;
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            removed_count_next = COUNT_W'(removed_reg);
                        end
                        FUNC_CLEAR:
                        begin
                            removed_count_next = COUNT_W'(fill_reg);
                            fill_next          = '0;
                        end
                        default:
                        begin
                            fill_next = fill_reg;
                        end
                    endcase
                    entry_count_next = COUNT_W'(fill_next);
                    rsp_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rd_reg            <= rd_next;
        wr_reg            <= wr_next;
        removed_reg       <= removed_next;
        op_reg            <= op_next;
        key_reg           <= key_next;
        entry_count_reg   <= entry_count_next;
        removed_count_reg <= removed_count_next;
        overflow_reg      <= overflow_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign entry_count   = entry_count_reg;
    assign removed_count = removed_count_reg;
    assign overflow      = overflow_reg;

`ifndef SYNTHESIS
    // list never holds more than its capacity
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill level above capacity");

    // compaction write pointer never overtakes the read pointer
    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (wr_reg <= rd_reg))
        else $error("scan write index passed read index");

    // an accepted transaction always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after accept");

    // result load never overwrites a pending result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && rsp_valid_reg && rsp_stall) |=>
            (state_reg == ST_FINISH))
        else $error("finish left while result slot busy");

    // a dropped append reports nothing removed
    a_overflow_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && overflow) |-> (removed_count == '0))
        else $error("overflow with nonzero removed count");
`endif

endmodule
